// ----- rtl/core/ssp_pkg.sv -----
// ----------------------------------------------------------------------------
// Sprite screen projection package
// Shared constants, register indexes and pipeline stage types.
// ----------------------------------------------------------------------------
package ssp_pkg;

   localparam int FRAC_BITS = 16;
   localparam int CFG_W     = 13;
   localparam int DIV_STEPS = 32;                    // quotient bits of tx / ty
   localparam int TLOW_W    = DIV_STEPS - FRAC_BITS; // dividend bits fed during steps
   localparam int CTR_STEPS = 16;                    // quotient bits of center
   localparam int SIZE_W    = CFG_W + FRAC_BITS;     // size quotient bits
   localparam int HALF_W    = SIZE_W - 1;
   localparam int AW        = SIZE_W + 1;            // signed row / col arithmetic
   localparam int NUM_W     = 46;                    // (w>>1) * (ty+tx)
   localparam int NMAG_W    = 45;

   localparam logic CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic CSR_SCREEN_HEIGHT = 1'b1;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

   typedef struct packed {
      logic [63:0]        den;
      logic [63:0]        rem_x;
      logic [63:0]        rem_y;
      logic [31:0]        quo_x;
      logic [31:0]        quo_y;
      logic [TLOW_W-1:0]  low_x;
      logic [TLOW_W-1:0]  low_y;
      logic               ovf_x;
      logic               ovf_y;
      logic               neg_x;
      logic               neg_y;
      logic               det_zero;
   } tdiv_type;

   typedef struct packed {
      logic [31:0]           den;
      logic [31:0]           rem_c;
      logic [CTR_STEPS-1:0]  quo_c;
      logic [CTR_STEPS-1:0]  low_c;
      logic                  ovf_c;
      logic                  neg_c;
      logic [31:0]           rem_s;
      logic [SIZE_W-1:0]     quo_s;
      logic signed [31:0]    ty;
      logic                  degen;
   } cdiv_type;

endpackage

// ----- rtl/core/sprite_screen_projection.sv -----
// Throughput: one word per cycle; two restoring dividers, one quotient bit per
// stage (32 stages for tx/ty, 29 for size with center alongside), set the depth.
// A response that is not taken stalls the whole pipeline.
// Reset (synchronous, active high) clears all valid bits and sets the screen
// to 640 x 480.
// ----------------------------------------------------------------------------
// Sprite screen projection
// Camera-space transform of a sprite and its projected screen rectangle.
// ----------------------------------------------------------------------------
module sprite_screen_projection (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic                        csr_index,
   input  logic [ssp_pkg::CFG_W-1:0]   csr_wdata,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [31:0]          req_sprite_x,
   input  logic signed [31:0]          req_sprite_y,
   input  logic signed [31:0]          req_cam_x,
   input  logic signed [31:0]          req_cam_y,
   input  logic signed [31:0]          req_dir_x,
   input  logic signed [31:0]          req_dir_y,
   input  logic signed [31:0]          req_plane_x,
   input  logic signed [31:0]          req_plane_y,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [31:0]          rsp_depth,
   output logic signed [15:0]          rsp_center_col,
   output logic [14:0]                 rsp_start_col,
   output logic signed [15:0]          rsp_end_col,
   output logic [14:0]                 rsp_start_row,
   output logic signed [15:0]          rsp_end_row,
   output logic                        rsp_in_front,
   output logic                        rsp_degenerate
);

   logic adv;

   logic [ssp_pkg::CFG_W-1:0] screen_w_ff, screen_h_ff;

   // stage 1: offsets
   logic                v1_ff;
   logic signed [31:0]  cx_ff, cy_ff, dx1_ff, dy1_ff, px1_ff, py1_ff;
   logic signed [31:0]  cx_in, cy_in;
   logic signed [32:0]  dcx, dcy;

   // stage 2: products
   logic                v2_ff;
   logic signed [63:0]  p_dycx_ff, p_dxcy_ff, p_pxcy_ff, p_pycx_ff, p_pxdy_ff, p_dxpy_ff;
   logic signed [63:0]  p_dycx_in, p_dxcy_in, p_pxcy_in, p_pycx_in, p_pxdy_in, p_dxpy_in;

   // stage 3: det, nx, ny
   logic                v3_ff;
   logic signed [63:0]  det_ff, nx_ff, ny_ff;

   // stage 4: magnitudes
   logic                v4_ff;
   logic [63:0]         mag_d_ff, mag_x_ff, mag_y_ff;
   logic                neg_x_ff, neg_y_ff, dzero_ff;

   // tx / ty divider
   logic [ssp_pkg::DIV_STEPS:0]  tvld_ff;
   ssp_pkg::tdiv_type            tdiv_ff [0:ssp_pkg::DIV_STEPS];
   ssp_pkg::tdiv_type            tdiv_in [0:ssp_pkg::DIV_STEPS];

   // tx / ty result
   logic                vt_ff;
   logic signed [31:0]  tx_ff, ty_ff, tx_in, ty_in;
   logic                degen_t_ff;

   // center numerator
   logic                vm_ff;
   logic signed [ssp_pkg::NUM_W-1:0]  num_ff, num_in;
   logic [31:0]         tymag_m_ff;
   logic signed [31:0]  ty_m_ff;
   logic                degen_m_ff;
   logic signed [32:0]  tsum;

   logic                vc_ff;
   logic [ssp_pkg::NMAG_W-1:0]  nmag_ff;
   logic                negc_ff;
   logic [31:0]         tymag_c_ff;
   logic signed [31:0]  ty_c_ff;
   logic                degen_c_ff;
   logic [ssp_pkg::NUM_W-1:0]   nmag_wide;

   // center / size divider
   logic [ssp_pkg::SIZE_W:0]  cvld_ff;
   ssp_pkg::cdiv_type         cdiv_ff [0:ssp_pkg::SIZE_W];
   ssp_pkg::cdiv_type         cdiv_in [0:ssp_pkg::SIZE_W];

   // final stages
   logic                         vf_ff;
   logic signed [15:0]           center_ff, center_in;
   logic [ssp_pkg::HALF_W-1:0]   half_ff;
   logic signed [31:0]           ty_f_ff;
   logic                         degen_f_ff;

   logic                vo_ff;
   logic signed [31:0]  o_depth_ff, o_depth_in;
   logic signed [15:0]  o_center_ff, o_center_in, o_ecol_ff, o_ecol_in, o_erow_ff, o_erow_in;
   logic [14:0]         o_scol_ff, o_scol_in, o_srow_ff, o_srow_in;
   logic                o_front_ff, o_front_in, o_degen_ff;

   assign adv       = !vo_ff || rsp_ready;
   assign req_ready = adv;

   // ---------------- control ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         screen_w_ff <= ssp_pkg::WIDTH_RESET;
         screen_h_ff <= ssp_pkg::HEIGHT_RESET;
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         v3_ff       <= 1'b0;
         v4_ff       <= 1'b0;
         tvld_ff     <= '0;
         vt_ff       <= 1'b0;
         vm_ff       <= 1'b0;
         vc_ff       <= 1'b0;
         cvld_ff     <= '0;
         vf_ff       <= 1'b0;
         vo_ff       <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               ssp_pkg::CSR_SCREEN_WIDTH:  screen_w_ff <= csr_wdata;
               ssp_pkg::CSR_SCREEN_HEIGHT: screen_h_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (adv) begin
            v1_ff   <= req_valid;
            v2_ff   <= v1_ff;
            v3_ff   <= v2_ff;
            v4_ff   <= v3_ff;
            tvld_ff <= {tvld_ff[ssp_pkg::DIV_STEPS-1:0], v4_ff};
            vt_ff   <= tvld_ff[ssp_pkg::DIV_STEPS];
            vm_ff   <= vt_ff;
            vc_ff   <= vm_ff;
            cvld_ff <= {cvld_ff[ssp_pkg::SIZE_W-1:0], vc_ff};
            vf_ff   <= cvld_ff[ssp_pkg::SIZE_W];
            vo_ff   <= vf_ff;
         end
      end
   end

   // ---------------- stage 1 ----------------
   always_comb begin
      dcx = {req_sprite_x[31], req_sprite_x} - {req_cam_x[31], req_cam_x};
      dcy = {req_sprite_y[31], req_sprite_y} - {req_cam_y[31], req_cam_y};
      if (dcx[32] != dcx[31]) begin
         cx_in = dcx[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
         cx_in = dcx[31:0];
      end
      if (dcy[32] != dcy[31]) begin
         cy_in = dcy[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
         cy_in = dcy[31:0];
      end
   end

   // ---------------- stage 2 ----------------
   always_comb begin
      p_dycx_in = dy1_ff * cx_ff;
      p_dxcy_in = dx1_ff * cy_ff;
      p_pxcy_in = px1_ff * cy_ff;
      p_pycx_in = py1_ff * cx_ff;
      p_pxdy_in = px1_ff * dy1_ff;
      p_dxpy_in = dx1_ff * py1_ff;
   end

   // ---------------- tx / ty division ----------------
   always_comb begin
      tdiv_in[0].den      = mag_d_ff;
      tdiv_in[0].ovf_x    = (mag_x_ff >> ssp_pkg::TLOW_W) >= mag_d_ff;
      tdiv_in[0].ovf_y    = (mag_y_ff >> ssp_pkg::TLOW_W) >= mag_d_ff;
      tdiv_in[0].rem_x    = mag_x_ff >> ssp_pkg::TLOW_W;
      tdiv_in[0].rem_y    = mag_y_ff >> ssp_pkg::TLOW_W;
      tdiv_in[0].low_x    = mag_x_ff[ssp_pkg::TLOW_W-1:0];
      tdiv_in[0].low_y    = mag_y_ff[ssp_pkg::TLOW_W-1:0];
      tdiv_in[0].quo_x    = '0;
      tdiv_in[0].quo_y    = '0;
      tdiv_in[0].neg_x    = neg_x_ff;
      tdiv_in[0].neg_y    = neg_y_ff;
      tdiv_in[0].det_zero = dzero_ff;
   end

   for (genvar k = 1; k <= ssp_pkg::DIV_STEPS; k++) begin : g_tdiv
      localparam int BI = ssp_pkg::DIV_STEPS - k;
      logic              nb_x, nb_y;
      logic [64:0]       tr_x, tr_y, sub_x, sub_y;
      ssp_pkg::tdiv_type nxt;

      if (BI >= ssp_pkg::FRAC_BITS) begin : g_bit
         assign nb_x = tdiv_ff[k-1].low_x[BI-ssp_pkg::FRAC_BITS];
         assign nb_y = tdiv_ff[k-1].low_y[BI-ssp_pkg::FRAC_BITS];
      end else begin : g_zero
         assign nb_x = 1'b0;
         assign nb_y = 1'b0;
      end

      always_comb begin
         nxt   = tdiv_ff[k-1];
         tr_x  = {tdiv_ff[k-1].rem_x, nb_x};
         tr_y  = {tdiv_ff[k-1].rem_y, nb_y};
         sub_x = tr_x - {1'b0, tdiv_ff[k-1].den};
         sub_y = tr_y - {1'b0, tdiv_ff[k-1].den};
         if (tr_x >= {1'b0, tdiv_ff[k-1].den}) begin
            nxt.rem_x = sub_x[63:0];
            nxt.quo_x = {tdiv_ff[k-1].quo_x[30:0], 1'b1};
         end else begin
            nxt.rem_x = tr_x[63:0];
            nxt.quo_x = {tdiv_ff[k-1].quo_x[30:0], 1'b0};
         end
         if (tr_y >= {1'b0, tdiv_ff[k-1].den}) begin
            nxt.rem_y = sub_y[63:0];
            nxt.quo_y = {tdiv_ff[k-1].quo_y[30:0], 1'b1};
         end else begin
            nxt.rem_y = tr_y[63:0];
            nxt.quo_y = {tdiv_ff[k-1].quo_y[30:0], 1'b0};
         end
      end

      assign tdiv_in[k] = nxt;
   end

   // saturate quotients to signed 32 bits
   always_comb begin
      if (tdiv_ff[ssp_pkg::DIV_STEPS].ovf_x || tdiv_ff[ssp_pkg::DIV_STEPS].quo_x[31]) begin
         tx_in = tdiv_ff[ssp_pkg::DIV_STEPS].neg_x ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
         tx_in = tdiv_ff[ssp_pkg::DIV_STEPS].neg_x ? -tdiv_ff[ssp_pkg::DIV_STEPS].quo_x
                                                    : tdiv_ff[ssp_pkg::DIV_STEPS].quo_x;
      end
      if (tdiv_ff[ssp_pkg::DIV_STEPS].ovf_y || tdiv_ff[ssp_pkg::DIV_STEPS].quo_y[31]) begin
         ty_in = tdiv_ff[ssp_pkg::DIV_STEPS].neg_y ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
         ty_in = tdiv_ff[ssp_pkg::DIV_STEPS].neg_y ? -tdiv_ff[ssp_pkg::DIV_STEPS].quo_y
                                                    : tdiv_ff[ssp_pkg::DIV_STEPS].quo_y;
      end
   end

   // ---------------- center numerator ----------------
   always_comb begin
      tsum   = {ty_ff[31], ty_ff} + {tx_ff[31], tx_ff};
      num_in = $signed({{(ssp_pkg::NUM_W - ssp_pkg::CFG_W + 1){1'b0}},
                        screen_w_ff[ssp_pkg::CFG_W-1:1]})
             * $signed({{(ssp_pkg::NUM_W - 33){tsum[32]}}, tsum});
      nmag_wide = num_ff[ssp_pkg::NUM_W-1] ? -num_ff : num_ff;
   end

   // ---------------- center / size division ----------------
   always_comb begin
      cdiv_in[0].den   = tymag_c_ff;
      cdiv_in[0].ovf_c = {{(32 + ssp_pkg::CTR_STEPS - ssp_pkg::NMAG_W){1'b0}},
                          nmag_ff[ssp_pkg::NMAG_W-1:ssp_pkg::CTR_STEPS]} >= tymag_c_ff;
      cdiv_in[0].rem_c = {{(32 + ssp_pkg::CTR_STEPS - ssp_pkg::NMAG_W){1'b0}},
                          nmag_ff[ssp_pkg::NMAG_W-1:ssp_pkg::CTR_STEPS]};
      cdiv_in[0].low_c = nmag_ff[ssp_pkg::CTR_STEPS-1:0];
      cdiv_in[0].quo_c = '0;
      cdiv_in[0].neg_c = negc_ff;
      cdiv_in[0].rem_s = '0;
      cdiv_in[0].quo_s = '0;
      cdiv_in[0].ty    = ty_c_ff;
      cdiv_in[0].degen = degen_c_ff;
   end

   for (genvar k = 1; k <= ssp_pkg::SIZE_W; k++) begin : g_cdiv
      localparam int SI = ssp_pkg::SIZE_W - k;
      logic              nb_s;
      logic [32:0]       tr_s, sub_s;
      ssp_pkg::cdiv_type nxt;

      if (SI >= ssp_pkg::FRAC_BITS) begin : g_sbit
         assign nb_s = screen_h_ff[SI-ssp_pkg::FRAC_BITS];
      end else begin : g_szero
         assign nb_s = 1'b0;
      end

      if (k <= ssp_pkg::CTR_STEPS) begin : g_ctr
         localparam int CI = ssp_pkg::CTR_STEPS - k;
         logic [32:0] tr_c, sub_c;
         always_comb begin
            nxt   = cdiv_ff[k-1];
            tr_s  = {cdiv_ff[k-1].rem_s, nb_s};
            sub_s = tr_s - {1'b0, cdiv_ff[k-1].den};
            tr_c  = {cdiv_ff[k-1].rem_c, cdiv_ff[k-1].low_c[CI]};
            sub_c = tr_c - {1'b0, cdiv_ff[k-1].den};
            if (tr_s >= {1'b0, cdiv_ff[k-1].den}) begin
               nxt.rem_s = sub_s[31:0];
               nxt.quo_s = {cdiv_ff[k-1].quo_s[ssp_pkg::SIZE_W-2:0], 1'b1};
            end else begin
               nxt.rem_s = tr_s[31:0];
               nxt.quo_s = {cdiv_ff[k-1].quo_s[ssp_pkg::SIZE_W-2:0], 1'b0};
            end
            if (tr_c >= {1'b0, cdiv_ff[k-1].den}) begin
               nxt.rem_c = sub_c[31:0];
               nxt.quo_c = {cdiv_ff[k-1].quo_c[ssp_pkg::CTR_STEPS-2:0], 1'b1};
            end else begin
               nxt.rem_c = tr_c[31:0];
               nxt.quo_c = {cdiv_ff[k-1].quo_c[ssp_pkg::CTR_STEPS-2:0], 1'b0};
            end
         end
      end else begin : g_size
         always_comb begin
            nxt   = cdiv_ff[k-1];
            tr_s  = {cdiv_ff[k-1].rem_s, nb_s};
            sub_s = tr_s - {1'b0, cdiv_ff[k-1].den};
            if (tr_s >= {1'b0, cdiv_ff[k-1].den}) begin
               nxt.rem_s = sub_s[31:0];
               nxt.quo_s = {cdiv_ff[k-1].quo_s[ssp_pkg::SIZE_W-2:0], 1'b1};
            end else begin
               nxt.rem_s = tr_s[31:0];
               nxt.quo_s = {cdiv_ff[k-1].quo_s[ssp_pkg::SIZE_W-2:0], 1'b0};
            end
         end
      end

      assign cdiv_in[k] = nxt;
   end

   // center clamp to signed 16 bits
   always_comb begin
      if (cdiv_ff[ssp_pkg::SIZE_W].ovf_c || cdiv_ff[ssp_pkg::SIZE_W].quo_c[15]) begin
         center_in = cdiv_ff[ssp_pkg::SIZE_W].neg_c ? 16'sh8000 : 16'sh7fff;
      end else begin
         center_in = cdiv_ff[ssp_pkg::SIZE_W].neg_c ? -cdiv_ff[ssp_pkg::SIZE_W].quo_c
                                                     : cdiv_ff[ssp_pkg::SIZE_W].quo_c;
      end
   end

   // ---------------- rows and columns ----------------
   logic [ssp_pkg::AW-1:0]        hh_x, half_x, h_x, w_x, erow_s;
   logic signed [ssp_pkg::AW-1:0] cen_x, srow_s, scol_s, ecol_s;

   always_comb begin
      hh_x   = {{(ssp_pkg::AW - ssp_pkg::CFG_W + 1){1'b0}},
                screen_h_ff[ssp_pkg::CFG_W-1:1]};
      half_x = {{(ssp_pkg::AW - ssp_pkg::HALF_W){1'b0}}, half_ff};
      h_x    = {{(ssp_pkg::AW - ssp_pkg::CFG_W){1'b0}}, screen_h_ff};
      w_x    = {{(ssp_pkg::AW - ssp_pkg::CFG_W){1'b0}}, screen_w_ff};
      cen_x  = {{(ssp_pkg::AW - 16){center_ff[15]}}, center_ff};
      srow_s = $signed(hh_x) - $signed(half_x);
      erow_s = hh_x + half_x;
      scol_s = cen_x - $signed(half_x);
      ecol_s = cen_x + $signed(half_x);

      o_depth_in  = ty_f_ff;
      o_center_in = center_ff;
      o_front_in  = !ty_f_ff[31] && (ty_f_ff != 32'sd0);
      o_srow_in   = srow_s[ssp_pkg::AW-1] ? 15'd0 : srow_s[14:0];
      o_scol_in   = scol_s[ssp_pkg::AW-1] ? 15'd0 : scol_s[14:0];
      if (erow_s >= h_x) begin
         o_erow_in = {{(16 - ssp_pkg::CFG_W){1'b0}}, screen_h_ff} - 16'sd1;
      end else begin
         o_erow_in = erow_s[15:0];
      end
      if (ecol_s >= $signed(w_x)) begin
         o_ecol_in = {{(16 - ssp_pkg::CFG_W){1'b0}}, screen_w_ff} - 16'sd1;
      end else begin
         o_ecol_in = ecol_s[15:0];
      end
      if (degen_f_ff) begin
         o_depth_in  = '0;
         o_center_in = '0;
         o_front_in  = 1'b0;
         o_srow_in   = '0;
         o_scol_in   = '0;
         o_erow_in   = '0;
         o_ecol_in   = '0;
      end
   end

   // ---------------- datapath registers ----------------
   always_ff @(posedge clock) begin
      if (adv) begin
         cx_ff  <= cx_in;
         cy_ff  <= cy_in;
         dx1_ff <= req_dir_x;
         dy1_ff <= req_dir_y;
         px1_ff <= req_plane_x;
         py1_ff <= req_plane_y;

         p_dycx_ff <= p_dycx_in;
         p_dxcy_ff <= p_dxcy_in;
         p_pxcy_ff <= p_pxcy_in;
         p_pycx_ff <= p_pycx_in;
         p_pxdy_ff <= p_pxdy_in;
         p_dxpy_ff <= p_dxpy_in;

         det_ff <= p_pxdy_ff - p_dxpy_ff;
         nx_ff  <= p_dycx_ff - p_dxcy_ff;
         ny_ff  <= p_pxcy_ff - p_pycx_ff;

         mag_d_ff <= det_ff[63] ? -det_ff : det_ff;
         mag_x_ff <= nx_ff[63] ? -nx_ff : nx_ff;
         mag_y_ff <= ny_ff[63] ? -ny_ff : ny_ff;
         neg_x_ff <= nx_ff[63] ^ det_ff[63];
         neg_y_ff <= ny_ff[63] ^ det_ff[63];
         dzero_ff <= (det_ff == 64'sd0);

         for (int i = 0; i <= ssp_pkg::DIV_STEPS; i++) begin
            tdiv_ff[i] <= tdiv_in[i];
         end

         tx_ff      <= tx_in;
         ty_ff      <= ty_in;
         degen_t_ff <= tdiv_ff[ssp_pkg::DIV_STEPS].det_zero || (ty_in == 32'sd0);

         num_ff     <= num_in;
         tymag_m_ff <= ty_ff[31] ? -ty_ff : ty_ff;
         ty_m_ff    <= ty_ff;
         degen_m_ff <= degen_t_ff;

         nmag_ff    <= nmag_wide[ssp_pkg::NMAG_W-1:0];
         negc_ff    <= num_ff[ssp_pkg::NUM_W-1] ^ ty_m_ff[31];
         tymag_c_ff <= tymag_m_ff;
         ty_c_ff    <= ty_m_ff;
         degen_c_ff <= degen_m_ff;

         for (int i = 0; i <= ssp_pkg::SIZE_W; i++) begin
            cdiv_ff[i] <= cdiv_in[i];
         end

         center_ff  <= center_in;
         half_ff    <= cdiv_ff[ssp_pkg::SIZE_W].quo_s[ssp_pkg::SIZE_W-1:1];
         ty_f_ff    <= cdiv_ff[ssp_pkg::SIZE_W].ty;
         degen_f_ff <= cdiv_ff[ssp_pkg::SIZE_W].degen;

         o_depth_ff  <= o_depth_in;
         o_center_ff <= o_center_in;
         o_scol_ff   <= o_scol_in;
         o_ecol_ff   <= o_ecol_in;
         o_srow_ff   <= o_srow_in;
         o_erow_ff   <= o_erow_in;
         o_front_ff  <= o_front_in;
         o_degen_ff  <= degen_f_ff;
      end
   end

   assign rsp_valid      = vo_ff;
   assign rsp_depth      = o_depth_ff;
   assign rsp_center_col = o_center_ff;
   assign rsp_start_col  = o_scol_ff;
   assign rsp_end_col    = o_ecol_ff;
   assign rsp_start_row  = o_srow_ff;
   assign rsp_end_row    = o_erow_ff;
   assign rsp_in_front   = o_front_ff;
   assign rsp_degenerate = o_degen_ff;

`ifndef SYNTHESIS
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_depth == 32'sd0 && rsp_center_col == 16'sd0 && !rsp_in_front)
      else $error("degenerate word carries geometry");

   a_front_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_in_front |-> !rsp_degenerate && !rsp_depth[31] && rsp_depth != 32'sd0)
      else $error("in_front without positive depth");

   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while response stalled");
`endif

endmodule
